>>> design/windowed_fold_accumulator_unit_defines.svh
// ----------------------------------------------------------------------------
// windowed fold accumulator assertion macros
// shared property forms for the checker of the fold accumulator
// ----------------------------------------------------------------------------
`ifndef WINDOWED_FOLD_ACCUMULATOR_UNIT_DEFINES_SVH
`define WINDOWED_FOLD_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define WFA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fold accumulator check failed");

// next-cycle implication
`define WFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fold accumulator check failed");

`endif

>>> design/wfa_pkg.sv
// ----------------------------------------------------------------------------
// wfa_pkg
// types and constants of the windowed fold accumulator
// ----------------------------------------------------------------------------
package wfa_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 48;
   localparam int ACC_HALF     = ACC_WIDTH / 2;
   localparam int OUT_WIDTH    = 32;
   localparam int BIN_WIDTH    = 10;
   localparam int SEG_WIDTH    = 11;
   localparam int FOLD_WIDTH   = 16;
   localparam int SCALE_WIDTH  = 17;
   localparam int FRAC_BITS    = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = SCALE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEGMENT_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOLD_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE          = 2'd2;

   localparam logic [SEG_WIDTH-1:0]   SEG_RESET   = 11'd1024;
   localparam logic [FOLD_WIDTH-1:0]  FOLD_RESET  = 16'd1;
   localparam logic [SCALE_WIDTH-1:0] SCALE_ONE   = 17'd65536;

   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_re;
      logic signed [SAMPLE_WIDTH-1:0] sample_im;
      logic signed [SAMPLE_WIDTH-1:0] weight;
      logic                           last_of_window;
   } req_type;

   typedef struct packed {
      logic [BIN_WIDTH-1:0]        bin_index;
      logic signed [OUT_WIDTH-1:0] out_re;
      logic signed [OUT_WIDTH-1:0] out_im;
      logic                        last_bin;
      logic                        saturated;
   } rsp_type;

endpackage

>>> design/wfa_ram.sv
// ----------------------------------------------------------------------------
// wfa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wfa_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/windowed_fold_accumulator_unit.sv
// ----------------------------------------------------------------------------
// windowed_fold_accumulator_unit
// windows complex samples and folds them into bins held in one ram
// ----------------------------------------------------------------------------
// req channel: one sample beat (re, im, weight, last_of_window), taken when
// req_valid is high and req_stall is low. rsp channel: one finished bin beat,
// taken when rsp_valid is high and rsp_stall is low. csr channel: register
// writes (segment length, fold count, scale), always ready; the user makes
// them only while idle, which the block does not enforce. A sample not
// discarded makes one read-modify-write of its bin in the accumulator ram;
// a discarded one is taken without leaving idle. One that only accumulates
// passes accept, product with ram read, add and write back; one on the last
// fold adds magnitude, the 48 x 17 bit scaling as two partial products,
// round and saturate into the output register. The next sample may be taken
// while that result waits; if the receiver stalls a second result, the block
// holds it internally and stalls req until the output register frees up.
// Reset clears the counters and restores the registers to their defaults;
// the ram is not cleared, as the first fold of every window writes each bin.
// ----------------------------------------------------------------------------
module windowed_fold_accumulator_unit #(
   parameter int MAX_BINS = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  wfa_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output wfa_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [wfa_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [wfa_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   import wfa_pkg::*;

   localparam int AW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int PW      = AW + 1;
   localparam int CW      = (PW > SEG_WIDTH) ? PW : SEG_WIDTH;
   localparam int FW      = FOLD_WIDTH + 1;
   localparam int PRODW   = 2 * SAMPLE_WIDTH;
   localparam int PPW     = ACC_HALF + SCALE_WIDTH;
   localparam int TOTW    = ACC_WIDTH + SCALE_WIDTH;
   localparam int RNDW    = TOTW - FRAC_BITS;
   localparam int RAMW    = 2 * ACC_WIDTH;

   localparam logic [16:0]     MAX_BINS_L = 17'(MAX_BINS);
   localparam logic [TOTW-1:0] ROUND_BIAS = TOTW'(1) << (FRAC_BITS - 1);
   localparam logic [RNDW-1:0] POS_LIMIT  = RNDW'(32'h7FFF_FFFF);
   localparam logic [RNDW-1:0] NEG_LIMIT  = RNDW'(32'h8000_0000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRODUCT,
      ST_ACCUMULATE,
      ST_MAGNITUDE,
      ST_MULTIPLY,
      ST_ROUND,
      ST_EMIT
   } state_type;

   function automatic logic [OUT_WIDTH:0] saturate(input logic neg, input logic [RNDW-1:0] mag);
      logic [OUT_WIDTH:0] res;
      if (!neg && mag > POS_LIMIT) begin
         res = {1'b1, OUT_MAX};
      end else if (neg && mag > NEG_LIMIT) begin
         res = {1'b1, OUT_MIN};
      end else if (neg) begin
         res = {1'b0, OUT_WIDTH'(0) - mag[OUT_WIDTH-1:0]};
      end else begin
         res = {1'b0, mag[OUT_WIDTH-1:0]};
      end
      return res;
   endfunction

   // configuration
   logic [SEG_WIDTH-1:0]   seg_ff;
   logic [FOLD_WIDTH-1:0]  folds_ff;
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [SEG_WIDTH-1:0]   seg_eff;
   logic [FOLD_WIDTH-1:0]  folds_eff;
   logic [SCALE_WIDTH-1:0] scale_eff;

   // counters
   logic [AW-1:0]          bin_ff;
   logic [AW-1:0]          bin_in;
   logic [FOLD_WIDTH-1:0]  fold_ff;
   logic [FOLD_WIDTH-1:0]  fold_in;
   logic                   done_ff;
   logic                   done_in;

   logic [CW-1:0]          bin_cur;
   logic [CW-1:0]          seg_cmp;
   logic                   wrap_pre;
   logic [CW-1:0]          bin_sel;
   logic [CW-1:0]          bin_inc;
   logic [FW-1:0]          fold_sel;
   logic [FW-1:0]          fold_inc;
   logic [FW-1:0]          fold_lim;
   logic                   done_sel;
   logic                   active;
   logic                   first_fold;
   logic                   last_fold;
   logic                   last_bin;

   // datapath
   state_type              state_ff;
   req_type                item_ff;
   logic [AW-1:0]          addr_ff;
   logic                   first_ff;
   logic                   last_fold_ff;
   logic                   last_bin_ff;
   logic signed [PRODW-1:0] prod_re;
   logic signed [PRODW-1:0] prod_im;
   logic [ACC_WIDTH-1:0]   prod_re_ff;
   logic [ACC_WIDTH-1:0]   prod_im_ff;
   logic [ACC_WIDTH-1:0]   sum_re;
   logic [ACC_WIDTH-1:0]   sum_im;
   logic [ACC_WIDTH-1:0]   acc_re_ff;
   logic [ACC_WIDTH-1:0]   acc_im_ff;
   logic                   neg_re_ff;
   logic                   neg_im_ff;
   logic [ACC_WIDTH-1:0]   mag_re_ff;
   logic [ACC_WIDTH-1:0]   mag_im_ff;
   logic [PPW-1:0]         plo_re_ff;
   logic [PPW-1:0]         phi_re_ff;
   logic [PPW-1:0]         plo_im_ff;
   logic [PPW-1:0]         phi_im_ff;
   logic [TOTW-1:0]        tot_re;
   logic [TOTW-1:0]        tot_im;
   logic [RNDW-1:0]        rnd_re_ff;
   logic [RNDW-1:0]        rnd_im_ff;
   logic [OUT_WIDTH:0]     sat_re;
   logic [OUT_WIDTH:0]     sat_im;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // ram
   logic                   ram_rd_en;
   logic                   ram_wr_en;
   logic [RAMW-1:0]        ram_rd_data;
   logic [ACC_WIDTH-1:0]   rd_re;
   logic [ACC_WIDTH-1:0]   rd_im;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_RESET;
         folds_ff <= FOLD_RESET;
         scale_ff <= SCALE_ONE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SEGMENT_LENGTH: seg_ff   <= csr_data[SEG_WIDTH-1:0];
            CSR_FOLD_COUNT:     folds_ff <= csr_data[FOLD_WIDTH-1:0];
            CSR_SCALE:          scale_ff <= csr_data[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (seg_ff == '0) begin
         seg_eff = SEG_WIDTH'(1);
      end else if (17'(seg_ff) > MAX_BINS_L) begin
         seg_eff = MAX_BINS_L[SEG_WIDTH-1:0];
      end else begin
         seg_eff = seg_ff;
      end
      folds_eff = (folds_ff == '0) ? FOLD_WIDTH'(1) : folds_ff;
      scale_eff = (scale_ff > SCALE_ONE) ? SCALE_ONE : scale_ff;
   end

   // position bookkeeping for the sample at the port
   always_comb begin
      bin_cur  = CW'(bin_ff);
      seg_cmp  = CW'(seg_eff);
      fold_lim = FW'(folds_eff);
      wrap_pre = !done_ff && (bin_cur >= seg_cmp);
      bin_sel  = wrap_pre ? '0 : bin_cur;
      fold_sel = wrap_pre ? FW'(fold_ff) + FW'(1) : FW'(fold_ff);
      done_sel = done_ff || (fold_sel >= fold_lim);
      active   = !done_sel;
      first_fold = (fold_sel == '0);
      last_fold  = (fold_sel == fold_lim - FW'(1));
      last_bin   = (bin_sel == seg_cmp - CW'(1));
      bin_inc  = bin_sel + CW'(1);
      fold_inc = fold_sel + FW'(1);
      if (active) begin
         if (bin_inc >= seg_cmp) begin
            bin_in  = '0;
            fold_in = fold_inc[FOLD_WIDTH-1:0];
            done_in = (fold_inc >= fold_lim);
         end else begin
            bin_in  = bin_inc[AW-1:0];
            fold_in = fold_sel[FOLD_WIDTH-1:0];
            done_in = 1'b0;
         end
      end else begin
         bin_in  = bin_sel[AW-1:0];
         fold_in = fold_sel[FOLD_WIDTH-1:0];
         done_in = done_sel;
      end
      if (req_data.last_of_window) begin
         bin_in  = '0;
         fold_in = '0;
         done_in = 1'b0;
      end
   end

   assign ram_rd_en = (state_ff == ST_IDLE) && req_valid && active;
   assign ram_wr_en = (state_ff == ST_ACCUMULATE);
   assign rd_re     = ram_rd_data[RAMW-1:ACC_WIDTH];
   assign rd_im     = ram_rd_data[ACC_WIDTH-1:0];

   assign prod_re = item_ff.sample_re * item_ff.weight;
   assign prod_im = item_ff.sample_im * item_ff.weight;
   assign sum_re  = first_ff ? prod_re_ff : rd_re + prod_re_ff;
   assign sum_im  = first_ff ? prod_im_ff : rd_im + prod_im_ff;

   assign tot_re = {phi_re_ff, {ACC_HALF{1'b0}}} + TOTW'(plo_re_ff) + ROUND_BIAS;
   assign tot_im = {phi_im_ff, {ACC_HALF{1'b0}}} + TOTW'(plo_im_ff) + ROUND_BIAS;
   assign sat_re = saturate(neg_re_ff, rnd_re_ff);
   assign sat_im = saturate(neg_im_ff, rnd_im_ff);

   wfa_ram #(
      .WIDTH (RAMW),
      .DEPTH (MAX_BINS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({sum_re, sum_im}),
      .rd_en   (ram_rd_en),
      .rd_addr (bin_sel[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bin_ff       <= '0;
         fold_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  bin_ff  <= bin_in;
                  fold_ff <= fold_in;
                  done_ff <= done_in;
                  if (active) begin
                     item_ff      <= req_data;
                     addr_ff      <= bin_sel[AW-1:0];
                     first_ff     <= first_fold;
                     last_fold_ff <= last_fold;
                     last_bin_ff  <= last_bin;
                     state_ff     <= ST_PRODUCT;
                  end
               end
            end
            ST_PRODUCT: begin
               prod_re_ff <= {{(ACC_WIDTH-PRODW){prod_re[PRODW-1]}}, prod_re};
               prod_im_ff <= {{(ACC_WIDTH-PRODW){prod_im[PRODW-1]}}, prod_im};
               state_ff   <= ST_ACCUMULATE;
            end
            ST_ACCUMULATE: begin
               acc_re_ff <= sum_re;
               acc_im_ff <= sum_im;
               state_ff  <= last_fold_ff ? ST_MAGNITUDE : ST_IDLE;
            end
            ST_MAGNITUDE: begin
               neg_re_ff <= acc_re_ff[ACC_WIDTH-1];
               neg_im_ff <= acc_im_ff[ACC_WIDTH-1];
               mag_re_ff <= acc_re_ff[ACC_WIDTH-1] ? '0 - acc_re_ff : acc_re_ff;
               mag_im_ff <= acc_im_ff[ACC_WIDTH-1] ? '0 - acc_im_ff : acc_im_ff;
               state_ff  <= ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
               plo_re_ff <= mag_re_ff[ACC_HALF-1:0] * scale_eff;
               phi_re_ff <= mag_re_ff[ACC_WIDTH-1:ACC_HALF] * scale_eff;
               plo_im_ff <= mag_im_ff[ACC_HALF-1:0] * scale_eff;
               phi_im_ff <= mag_im_ff[ACC_WIDTH-1:ACC_HALF] * scale_eff;
               state_ff  <= ST_ROUND;
            end
            ST_ROUND: begin
               rnd_re_ff <= tot_re[TOTW-1:FRAC_BITS];
               rnd_im_ff <= tot_im[TOTW-1:FRAC_BITS];
               state_ff  <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_data_ff.bin_index <= BIN_WIDTH'(addr_ff);
                  rsp_data_ff.out_re    <= sat_re[OUT_WIDTH-1:0];
                  rsp_data_ff.out_im    <= sat_im[OUT_WIDTH-1:0];
                  rsp_data_ff.last_bin  <= last_bin_ff;
                  rsp_data_ff.saturated <= sat_re[OUT_WIDTH] | sat_im[OUT_WIDTH];
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> design/wfa_checker.sv
// ----------------------------------------------------------------------------
// wfa_checker
// port-level checks of the fold accumulator, bound to the top level
// ----------------------------------------------------------------------------
`include "windowed_fold_accumulator_unit_defines.svh"

module wfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input wfa_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wfa_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);

   import wfa_pkg::*;

   // a stalled result beat holds
   `WFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a new result only comes out of a busy period
   `WFA_ASSERT_HOLDS(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // the block only goes busy after taking a sample beat
   `WFA_ASSERT_HOLDS(a_busy_after_req, clock, reset, $rose(req_stall), $past(req_valid))

   // a clipped beat carries a rail value in at least one part
   `WFA_ASSERT_HOLDS(a_sat_rail, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.out_re == OUT_MAX || rsp_data.out_re == OUT_MIN || rsp_data.out_im == OUT_MAX || rsp_data.out_im == OUT_MIN)

   // the register port never blocks
   `WFA_ASSERT_HOLDS(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind windowed_fold_accumulator_unit wfa_checker u_wfa_checker (.*);

>>> sim/windowed_fold_accumulator_unit_checker.sv
// ----------------------------------------------------------------------------
// windowed_fold_accumulator_unit_checker
// watches the sample, bin and register channels of the fold accumulator,
// keeps its own copy of the bins and counters, works out every finished bin
// beat and compares each arriving bin beat with the oldest one, field by field
// ----------------------------------------------------------------------------
module windowed_fold_accumulator_unit_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  wfa_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  wfa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [wfa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wfa_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  bins_awaited
);
   import wfa_pkg::*;

   localparam int BIN_SLOTS = 1024;

   logic [SEG_WIDTH-1:0]   seg_reg;
   logic [FOLD_WIDTH-1:0]  fold_reg;
   logic [SCALE_WIDTH-1:0] scale_reg;
   logic [ACC_WIDTH-1:0]   sum_re [BIN_SLOTS];
   logic [ACC_WIDTH-1:0]   sum_im [BIN_SLOTS];
   logic [SEG_WIDTH-1:0]   bin_pos;
   logic [FOLD_WIDTH:0]    fold_pos;
   logic                   window_done;
   rsp_type                folded_bins [$];
   rsp_type                want;

   // scaled, rounded half away from zero, clipped; top bit flags the clip
   function automatic logic [OUT_WIDTH:0] scale_and_clip(input logic [ACC_WIDTH-1:0] acc,
                                                         input logic [SCALE_WIDTH-1:0] sc);
      logic            neg;
      logic [ACC_WIDTH-1:0] mag;
      logic [65:0]     prod;
      neg  = acc[ACC_WIDTH-1];
      mag  = neg ? (~acc + 48'd1) : acc;
      prod = ({18'd0, mag} * {49'd0, sc}) + 66'd32768;
      prod = prod >> FRAC_BITS;
      if (!neg && prod > 66'h7FFF_FFFF) return {1'b1, OUT_MAX};
      if (neg && prod > 66'h8000_0000) return {1'b1, OUT_MIN};
      return {1'b0, neg ? (32'd0 - prod[OUT_WIDTH-1:0]) : prod[OUT_WIDTH-1:0]};
   endfunction

   task automatic fold_sample(input req_type s);
      logic [SEG_WIDTH-1:0]             seg;
      logic [FOLD_WIDTH:0]              folds;
      logic [SCALE_WIDTH-1:0]           sc;
      logic signed [2*SAMPLE_WIDTH-1:0] p_re;
      logic signed [2*SAMPLE_WIDTH-1:0] p_im;
      logic [ACC_WIDTH-1:0]             x_re;
      logic [ACC_WIDTH-1:0]             x_im;
      logic [BIN_WIDTH-1:0]             b;
      logic [OUT_WIDTH:0]               q_re;
      logic [OUT_WIDTH:0]               q_im;
      rsp_type                          r;
      seg   = (seg_reg == 0) ? 11'd1 : (seg_reg > BIN_SLOTS) ? 11'd1024 : seg_reg;
      folds = (fold_reg == 0) ? 17'd1 : {1'b0, fold_reg};
      sc    = (scale_reg > SCALE_ONE) ? SCALE_ONE : scale_reg;
      // registers shrunk while a window was open
      if (!window_done && bin_pos >= seg) begin
         bin_pos  = 0;
         fold_pos = fold_pos + 1;
      end
      if (!window_done && fold_pos >= folds) window_done = 1'b1;
      if (!window_done) begin
         b    = bin_pos[BIN_WIDTH-1:0];
         p_re = $signed(s.sample_re) * $signed(s.weight);
         p_im = $signed(s.sample_im) * $signed(s.weight);
         x_re = {{(ACC_WIDTH-2*SAMPLE_WIDTH){p_re[2*SAMPLE_WIDTH-1]}}, p_re};
         x_im = {{(ACC_WIDTH-2*SAMPLE_WIDTH){p_im[2*SAMPLE_WIDTH-1]}}, p_im};
         if (fold_pos == 0) begin
            sum_re[b] = x_re;
            sum_im[b] = x_im;
         end else begin
            sum_re[b] = sum_re[b] + x_re;
            sum_im[b] = sum_im[b] + x_im;
         end
         if (fold_pos == folds - 1) begin
            q_re        = scale_and_clip(sum_re[b], sc);
            q_im        = scale_and_clip(sum_im[b], sc);
            r.bin_index = b;
            r.out_re    = q_re[OUT_WIDTH-1:0];
            r.out_im    = q_im[OUT_WIDTH-1:0];
            r.last_bin  = ({1'b0, b} == seg - 1);
            r.saturated = q_re[OUT_WIDTH] | q_im[OUT_WIDTH];
            folded_bins.push_back(r);
         end
         bin_pos = bin_pos + 1;
         if (bin_pos >= seg) begin
            bin_pos  = 0;
            fold_pos = fold_pos + 1;
            if (fold_pos >= folds) window_done = 1'b1;
         end
      end
      if (s.last_of_window) begin
         bin_pos     = 0;
         fold_pos    = 0;
         window_done = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [OUT_WIDTH-1:0] exp_v,
                              input logic [OUT_WIDTH-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: bin beat %s expected %h, got %h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seg_reg        = SEG_RESET;
         fold_reg       = FOLD_RESET;
         scale_reg      = SCALE_ONE;
         bin_pos        = 0;
         fold_pos       = 0;
         window_done    = 1'b0;
         mismatch_count = 0;
         folded_bins.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEGMENT_LENGTH: seg_reg   = csr_data[SEG_WIDTH-1:0];
               CSR_FOLD_COUNT:     fold_reg  = csr_data[FOLD_WIDTH-1:0];
               CSR_SCALE:          scale_reg = csr_data[SCALE_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (folded_bins.size() == 0) begin
               $display("%0t: bin beat expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = folded_bins.pop_front();
               check_field("bin_index", want.bin_index, rsp_data.bin_index);
               check_field("out_re", want.out_re, rsp_data.out_re);
               check_field("out_im", want.out_im, rsp_data.out_im);
               check_field("last_bin", want.last_bin, rsp_data.last_bin);
               check_field("saturated", want.saturated, rsp_data.saturated);
            end
         end
         if (req_valid && !req_stall) fold_sample(req_data);
      end
      bins_awaited = folded_bins.size();
   end

endmodule

>>> sim/windowed_fold_accumulator_unit_tb.sv
// ----------------------------------------------------------------------------
// windowed_fold_accumulator_unit_tb
// drives sample beats and register writes into the fold accumulator: a short
// directed run over the rails, the clamped register values, early and late
// window ends and registers shrunk inside a window, then random windows under
// random settings with idle bursts on both channels; the checker beside the
// block predicts and compares every bin beat
// ----------------------------------------------------------------------------
module windowed_fold_accumulator_unit_tb;
   import wfa_pkg::*;

   localparam int DRAIN_CYCLES  = 16;
   localparam int SAMPLE_TARGET = 1530;
   localparam int CALM_AFTER    = 1350;
   localparam int LIMIT_CYCLES  = 400000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef enum {WIN_WHOLE, WIN_EARLY, WIN_NOISE, WIN_BROKEN} window_kind_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   int                         mismatch_count;
   int                         bins_awaited;

   int gap_odds;
   int stall_odds;
   int stall_left;
   int samples_sent;
   int seg_live;
   bit at_window_start;

   windowed_fold_accumulator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   windowed_fold_accumulator_unit_checker fold_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .bins_awaited   (bins_awaited)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver stall bursts at random
   always @(negedge clock) begin
      if (reset || stall_odds == 0) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, stall_odds - 1) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int eff_seg(input logic [SEG_WIDTH-1:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return int'(v);
   endfunction

   function automatic int eff_fold(input logic [FOLD_WIDTH-1:0] v);
      if (v == 0) return 1;
      return int'(v);
   endfunction

   function automatic int rand_q15();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic put_sample(input int re, input int im, input int w, input bit last);
      req_type beat;
      beat.sample_re      = re[SAMPLE_WIDTH-1:0];
      beat.sample_im      = im[SAMPLE_WIDTH-1:0];
      beat.weight         = w[SAMPLE_WIDTH-1:0];
      beat.last_of_window = last;
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      at_window_start = last;
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SEGMENT_LENGTH) seg_live = eff_seg(data[SEG_WIDTH-1:0]);
   endtask

   // stop sending, let every bin beat arrive, then cover the pipeline depth
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bins_awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input bit big);
      logic [SEG_WIDTH-1:0]   seg_v;
      logic [FOLD_WIDTH-1:0]  fold_v;
      logic [SCALE_WIDTH-1:0] scale_v;
      window_kind_type        kind;
      int                     span;
      int                     n;
      int                     pick;
      if (big) begin
         if (!at_window_start) begin
            put_sample(rand_q15(), rand_q15(), rand_q15(), 1'b1);
            settle();
         end
         seg_v  = 11'd1024;
         fold_v = 16'd1;
      end else begin
         case ($urandom_range(0, 15))
            0: seg_v = 11'd0;
            1: seg_v = 11'd1;
            2: seg_v = $urandom_range(1025, 2047);
            default: seg_v = $urandom_range(1, 24);
         endcase
         // growing the bins is only safe at the start of a window
         if (!at_window_start && eff_seg(seg_v) > seg_live) seg_v = $urandom_range(0, seg_live);
         case ($urandom_range(0, 11))
            0: fold_v = 16'd0;
            1: fold_v = 16'hFFFF;
            2: fold_v = $urandom_range(5, 40);
            default: fold_v = $urandom_range(1, 4);
         endcase
      end
      case ($urandom_range(0, 7))
         0: scale_v = 17'd0;
         1: scale_v = SCALE_ONE;
         2: scale_v = 17'h1FFFF;
         3: scale_v = $urandom_range(65537, 131071);
         default: scale_v = $urandom_range(0, 65536);
      endcase
      write_reg(CSR_SEGMENT_LENGTH, {6'($urandom), seg_v});
      write_reg(CSR_FOLD_COUNT, {1'($urandom), fold_v});
      write_reg(CSR_SCALE, scale_v);
      if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE, 17'($urandom));
      if (samples_sent > CALM_AFTER) begin
         gap_odds   = 0;
         stall_odds = 0;
      end else begin
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 2;
            default: gap_odds = 5;
         endcase
         case ($urandom_range(0, 2))
            0: stall_odds = 0;
            1: stall_odds = 3;
            default: stall_odds = 6;
         endcase
      end
      span = seg_live * eff_fold(fold_v);
      repeat (big ? 1 : $urandom_range(1, 3)) begin
         pick = $urandom_range(0, 9);
         if (big) kind = WIN_WHOLE;
         else if (span > 300) kind = WIN_EARLY;
         else if (pick < 6) kind = WIN_WHOLE;
         else if (pick < 8) kind = WIN_EARLY;
         else if (pick < 9) kind = WIN_NOISE;
         else kind = WIN_BROKEN;
         case (kind)
            WIN_WHOLE: begin
               // a few discarded beats may trail the finished window
               n = span + (big ? 0 : $urandom_range(0, 2));
               for (int i = 0; i < n; i++)
                  put_sample(rand_q15(), rand_q15(), rand_q15(), i == n - 1);
            end
            WIN_EARLY: begin
               n = $urandom_range(1, span < 60 ? span : 60);
               for (int i = 0; i < n; i++)
                  put_sample(rand_q15(), rand_q15(), rand_q15(), i == n - 1);
            end
            WIN_NOISE: begin
               n = $urandom_range(1, span + 3 < 60 ? span + 3 : 60);
               for (int i = 0; i < n; i++)
                  put_sample(rand_q15(), rand_q15(), rand_q15(), $urandom_range(0, 7) == 0);
            end
            default: begin
               n = span < 60 ? span : 60;
               for (int i = 0; i < n; i++)
                  put_sample(rand_q15(), rand_q15(), rand_q15(), 1'b0);
            end
         endcase
      end
      settle();
   endtask

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      bit big_done;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      gap_odds        = 0;
      stall_odds      = 0;
      stall_left      = 0;
      samples_sent    = 0;
      seg_live        = 1024;
      at_window_start = 1'b1;
      big_done        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_odds   = 3;
      stall_odds = 3;

      // both folds at the rails, positive clip, then a beat after the window
      write_reg(CSR_SEGMENT_LENGTH, 17'd4);
      write_reg(CSR_FOLD_COUNT, 17'd2);
      write_reg(CSR_SCALE, SCALE_ONE);
      repeat (2) begin
         put_sample(-32768, -32768, -32768, 1'b0);
         put_sample(32767, -32768, 32767, 1'b0);
         put_sample(0, 0, 0, 1'b0);
         put_sample(-1, 1, 1, 1'b0);
      end
      put_sample(100, -100, 100, 1'b1);
      settle();

      // zero segment length, scale above one, clip at both rails
      write_reg(CSR_SEGMENT_LENGTH, 17'd0);
      write_reg(CSR_FOLD_COUNT, 17'd3);
      write_reg(CSR_SCALE, 17'h1FFFF);
      put_sample(-32768, 32767, 32767, 1'b0);
      put_sample(-32768, 32767, 32767, 1'b0);
      put_sample(-32768, 32767, 32767, 1'b1);
      settle();

      // oversized segment length, zero fold count, zero scale
      write_reg(CSR_SEGMENT_LENGTH, 17'd2047);
      write_reg(CSR_FOLD_COUNT, 17'd0);
      write_reg(CSR_SCALE, 17'd0);
      put_sample(32767, 32767, -32768, 1'b0);
      put_sample(-32768, -32768, -32768, 1'b1);
      settle();

      // half scale with ties, window ended early in the last fold
      write_reg(CSR_SEGMENT_LENGTH, 17'd3);
      write_reg(CSR_FOLD_COUNT, 17'd2);
      write_reg(CSR_SCALE, 17'd32768);
      put_sample(-1, 1, 1, 1'b0);
      put_sample(1, -1, 1, 1'b0);
      put_sample(3, -3, 1, 1'b0);
      put_sample(0, 2, 1, 1'b1);
      settle();

      // segment length shrunk inside a window
      write_reg(CSR_SCALE, SCALE_ONE);
      put_sample(12345, -23456, 32767, 1'b0);
      put_sample(-32768, 32767, -32768, 1'b0);
      settle();
      write_reg(CSR_SEGMENT_LENGTH, 17'd1);
      put_sample(32767, 32767, 32767, 1'b1);
      settle();

      // fold count shrunk inside a window
      write_reg(CSR_SEGMENT_LENGTH, 17'd2);
      write_reg(CSR_FOLD_COUNT, 17'd4);
      put_sample(1000, -1000, 20000, 1'b0);
      put_sample(-32768, -32768, 32767, 1'b0);
      put_sample(32767, 0, -32768, 1'b0);
      put_sample(-5, 7, 9, 1'b0);
      settle();
      write_reg(CSR_FOLD_COUNT, 17'd2);
      put_sample(4242, -4242, 32767, 1'b1);
      settle();

      while (samples_sent < SAMPLE_TARGET) begin
         if (!big_done && samples_sent >= 400) begin
            random_phase(1'b1);
            big_done = 1'b1;
         end else begin
            random_phase(1'b0);
         end
      end

      settle();
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

>>> windowed_fold_accumulator_unit.f
+incdir+design
design/wfa_pkg.sv
design/wfa_ram.sv
design/windowed_fold_accumulator_unit.sv
design/wfa_checker.sv
sim/windowed_fold_accumulator_unit_checker.sv
sim/windowed_fold_accumulator_unit_tb.sv
